@@ hdl/ypu_pkg.sv @@
// ============================================================================
// ypu_pkg - shared types and constants for the yaw/pitch pose update block
// Holds the CORDIC angle table, controller command/status structs and the
// fixed-point helpers used by the datapath.
// ============================================================================
package ypu_pkg;

    localparam int AtanLen = 24;

    // Converged CORDIC gain in Q2.30.
    localparam logic signed [33:0] GainQ30 = 34'sd652032874;
    localparam logic signed [31:0] OneQ16  = 32'sd65536;

    // Input function codes
    localparam logic FuncLoad = 1'b0;
    localparam logic FuncStep = 1'b1;

    // Datapath operation codes issued by the controller
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CAPTURE = 4'd1,
        OP_LOAD    = 4'd2,
        OP_CINIT   = 4'd3,
        OP_CSTEP   = 4'd4,
        OP_CDONE   = 4'd5,
        OP_MUL     = 4'd6,
        OP_POS     = 4'd7
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       sel_yaw;   // CORDIC operand: 0 pitch, 1 yaw
        logic [3:0] mul_idx;   // multiply slot for OP_MUL
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_last;     // final CORDIC step on this cycle
    } dp_sts_t;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sh20000000;
            5'd1:  v = 34'sh12E4051E;
            5'd2:  v = 34'sh09FB385B;
            5'd3:  v = 34'sh051111D4;
            5'd4:  v = 34'sh028B0D43;
            5'd5:  v = 34'sh0145D7E1;
            5'd6:  v = 34'sh00A2F61E;
            5'd7:  v = 34'sh00517C55;
            5'd8:  v = 34'sh0028BE53;
            5'd9:  v = 34'sh00145F2F;
            5'd10: v = 34'sh000A2F98;
            5'd11: v = 34'sh000517CC;
            5'd12: v = 34'sh00028BE6;
            5'd13: v = 34'sh000145F3;
            5'd14: v = 34'sh0000A2FA;
            5'd15: v = 34'sh0000517D;
            5'd16: v = 34'sh000028BE;
            5'd17: v = 34'sh0000145F;
            5'd18: v = 34'sh00000A30;
            5'd19: v = 34'sh00000518;
            5'd20: v = 34'sh0000028C;
            5'd21: v = 34'sh00000146;
            5'd22: v = 34'sh000000A3;
            5'd23: v = 34'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh07FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -36'sh080000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ hdl/yaw_pitch_pose_update_top.sv @@
// ============================================================================
// yaw_pitch_pose_update_top - camera pose update with yaw/pitch matrix
// Keeps a camera position; a step rotates a move by yaw and pitch, adds it
// and transfers the four rows of pitch * yaw * translation.
// ============================================================================
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  input   | in_valid / in_ready   | func, pitch_angle, yaw_angle, move_x/y/z
//  output  | out_valid / out_ready | row_index, elem0..elem3, last_row
//
//  A load writes the position directly. A step runs two passes of the
//  shared CORDIC unit, eleven products in the single multiplier and the
//  position update, then moves one row per cycle while out_ready is high.
//  Reset clears the position and the sequencer. Output stalls hold the row.
module yaw_pitch_pose_update_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [31:0] move_x,
    input  logic signed [31:0] move_y,
    input  logic signed [31:0] move_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         row_index,
    output logic signed [31:0] elem0,
    output logic signed [31:0] elem1,
    output logic signed [31:0] elem2,
    output logic signed [31:0] elem3,
    output logic               last_row
);

    ypu_pkg::dp_cmd_t cmd;
    ypu_pkg::dp_sts_t sts;
    logic [1:0]       row_sel;

    ypu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .sts       (sts),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row_sel   (row_sel)
    );

    ypu_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .move_x      (move_x),
        .move_y      (move_y),
        .move_z      (move_z),
        .row_sel     (row_sel),
        .elem0       (elem0),
        .elem1       (elem1),
        .elem2       (elem2),
        .elem3       (elem3)
    );

    assign row_index = row_sel;
    assign last_row  = (row_sel == 2'd3);

    // Never take input while rows are pending
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input ready while rows pending");

    // Rows advance in order on each output transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && row_index != 2'd3
        |=> out_valid && row_index == $past(row_index) + 2'd1)
        else $error("row order broken");

    // Last row transfer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_row |=> in_ready)
        else $error("no return to idle after last row");

endmodule

@@ hdl/ypu_ctrl.sv @@
// ============================================================================
// ypu_ctrl - pose update sequencer
// Walks a step item through capture, two CORDIC runs, the product schedule,
// the position update and four row transfers; a load is done in idle.
// ============================================================================
module ypu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  ypu_pkg::dp_sts_t   sts,
    output ypu_pkg::dp_cmd_t   cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         row_sel
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CINIT  = 7'b0000010,
        S_CSTEP  = 7'b0000100,
        S_CDONE  = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_POS    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    localparam logic [3:0] MulLast = 4'd10;

    state_t     state_reg, state_next;
    logic       yaw_reg, yaw_next;
    logic [3:0] mul_reg, mul_next;
    logic [1:0] row_reg, row_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign row_sel   = row_reg;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        yaw_next    = yaw_reg;
        mul_next    = mul_reg;
        row_next    = row_reg;
        cmd.op      = ypu_pkg::OP_NONE;
        cmd.sel_yaw = yaw_reg;
        cmd.mul_idx = mul_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == ypu_pkg::FuncStep)
                    begin
                        cmd.op     = ypu_pkg::OP_CAPTURE;
                        state_next = S_CINIT;
                        yaw_next   = 1'b0;
                    end
                    else
                    begin
                        cmd.op = ypu_pkg::OP_LOAD;
                    end
                end
            end
            S_CINIT:
            begin
                cmd.op     = ypu_pkg::OP_CINIT;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.op = ypu_pkg::OP_CSTEP;
                if (sts.cordic_last)
                    state_next = S_CDONE;
            end
            S_CDONE:
            begin
                cmd.op = ypu_pkg::OP_CDONE;
                if (yaw_reg)
                begin
                    state_next = S_MUL;
                    mul_next   = '0;
                end
                else
                begin
                    yaw_next   = 1'b1;
                    state_next = S_CINIT;
                end
            end
            S_MUL:
            begin
                cmd.op   = ypu_pkg::OP_MUL;
                mul_next = mul_reg + 4'd1;
                if (mul_reg == MulLast)
                    state_next = S_POS;
            end
            S_POS:
            begin
                cmd.op     = ypu_pkg::OP_POS;
                state_next = S_OUT;
                row_next   = '0;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd3)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            yaw_reg   <= 1'b0;
            mul_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            yaw_reg   <= yaw_next;
            mul_reg   <= mul_next;
            row_reg   <= row_next;
        end
    end

endmodule

@@ hdl/ypu_dp.sv @@
// ============================================================================
// ypu_dp - pose update datapath
// Shared iterative CORDIC, one registered 36x18 multiplier with rounding,
// position registers and the row output mux.
// ============================================================================
module ypu_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ypu_pkg::dp_cmd_t    cmd,
    output ypu_pkg::dp_sts_t    sts,
    input  logic signed [15:0]  pitch_angle,
    input  logic signed [15:0]  yaw_angle,
    input  logic signed [31:0]  move_x,
    input  logic signed [31:0]  move_y,
    input  logic signed [31:0]  move_z,
    input  logic [1:0]          row_sel,
    output logic signed [31:0]  elem0,
    output logic signed [31:0]  elem1,
    output logic signed [31:0]  elem2,
    output logic signed [31:0]  elem3
);

    localparam int Steps = (CORDIC_STEPS < ypu_pkg::AtanLen) ? CORDIC_STEPS
                                                             : ypu_pkg::AtanLen;

    // Captured item
    logic signed [15:0] pa_reg, ya_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    // Sine/cosine results, Q16.16 (fit in 18 bits)
    logic signed [31:0] ps_reg, pc_reg, ys_reg, yc_reg;
    // CORDIC state
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]         ci_reg;
    logic               flip_reg;
    // Products, rounded but kept unclamped at 36 bits (a move times a trig value may pass 32 bits)
    logic signed [35:0] p_reg [0:10];
    logic signed [31:0] pos_reg [0:2];

    // Product schedule: a * b per slot (dependent slots come after sources)
    logic signed [35:0] ma;
    logic signed [17:0] mb;
    logic signed [53:0] prod;
    logic signed [35:0] prod_rnd;

    always_comb
    begin
        case (cmd.mul_idx)
            4'd0:    begin ma = 36'(tz_reg); mb = ys_reg[17:0]; end
            4'd1:    begin ma = 36'(tx_reg); mb = yc_reg[17:0]; end
            4'd2:    begin ma = 36'(tz_reg); mb = ps_reg[17:0]; end
            4'd3:    begin ma = 36'(tz_reg); mb = yc_reg[17:0]; end
            4'd4:    begin ma = 36'(tx_reg); mb = ys_reg[17:0]; end
            4'd5:    begin ma = 36'(ps_reg); mb = ys_reg[17:0]; end
            4'd6:    begin ma = 36'(ps_reg); mb = yc_reg[17:0]; end
            4'd7:    begin ma = p_reg[0];    mb = pc_reg[17:0]; end
            4'd8:    begin ma = p_reg[3];    mb = pc_reg[17:0]; end
            4'd9:    begin ma = 36'(pc_reg); mb = ys_reg[17:0]; end
            4'd10:   begin ma = 36'(pc_reg); mb = yc_reg[17:0]; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod     = ma * mb;
        prod_rnd = 36'((prod + 54'sd32768) >>> 16);
    end

    // CORDIC step
    logic signed [33:0] sh_x, sh_y, at;
    logic [4:0]         step_idx;
    logic [31:0]        ang_w;
    logic               flip_w;
    logic signed [33:0] rx, ry;

    always_comb
    begin
        sh_x   = cx_reg >>> ci_reg;
        sh_y   = cy_reg >>> ci_reg;
        at     = ypu_pkg::atan_entry(ci_reg);
        step_idx = ci_reg;
        ang_w  = {(cmd.sel_yaw ? ya_reg : pa_reg), 16'h0000};
        flip_w = (ang_w[31:30] == 2'b01) || (ang_w[31:30] == 2'b10);
        if (flip_w)
            ang_w = ang_w + 32'h80000000;
        // round Q2.30 to Q16.16
        rx = (cx_reg + 34'sd8192) >>> 14;
        ry = (cy_reg + 34'sd8192) >>> 14;
    end

    assign sts.cordic_last = (step_idx == 5'(Steps - 1));

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ypu_pkg::OP_CAPTURE:
            begin
                pa_reg <= pitch_angle;
                ya_reg <= yaw_angle;
                tx_reg <= move_x;
                ty_reg <= move_y;
                tz_reg <= move_z;
            end
            ypu_pkg::OP_CINIT:
            begin
                cx_reg   <= ypu_pkg::GainQ30;
                cy_reg   <= '0;
                cz_reg   <= {{2{ang_w[31]}}, ang_w};
                ci_reg   <= '0;
                flip_reg <= flip_w;
            end
            ypu_pkg::OP_CSTEP:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + at;
                end
                ci_reg <= ci_reg + 5'd1;
            end
            ypu_pkg::OP_CDONE:
            begin
                if (cmd.sel_yaw)
                begin
                    yc_reg <= flip_reg ? -32'(rx) : 32'(rx);
                    ys_reg <= flip_reg ? -32'(ry) : 32'(ry);
                end
                else
                begin
                    pc_reg <= flip_reg ? -32'(rx) : 32'(rx);
                    ps_reg <= flip_reg ? -32'(ry) : 32'(ry);
                end
            end
            ypu_pkg::OP_MUL:
            begin
                // no clamping here; only the position sums saturate
                p_reg[cmd.mul_idx] <= prod_rnd;
            end
            default:
            begin
            end
        endcase
    end

    // Position state. Each term stays below 2^33 in magnitude, so the
    // 36-bit sums are exact before saturation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= '0;
        end
        else if (cmd.op == ypu_pkg::OP_LOAD)
        begin
            pos_reg[0] <= move_x;
            pos_reg[1] <= move_y;
            pos_reg[2] <= move_z;
        end
        else if (cmd.op == ypu_pkg::OP_POS)
        begin
            pos_reg[0] <= ypu_pkg::sat32(36'(pos_reg[0]) + p_reg[7] + p_reg[1]);
            pos_reg[1] <= ypu_pkg::sat32(36'(pos_reg[1]) + 36'(ty_reg) + p_reg[2]);
            pos_reg[2] <= ypu_pkg::sat32(36'(pos_reg[2]) + p_reg[8] - p_reg[4]);
        end
    end

    // Row mux (trig products are near unit size, low 32 bits hold them)
    always_comb
    begin
        case (row_sel)
            2'd0:
            begin
                elem0 = yc_reg; elem1 = '0; elem2 = -ys_reg; elem3 = '0;
            end
            2'd1:
            begin
                elem0 = -p_reg[5][31:0]; elem1 = pc_reg;
                elem2 = -p_reg[6][31:0]; elem3 = '0;
            end
            2'd2:
            begin
                elem0 = p_reg[9][31:0];
                elem1 = ps_reg; elem2 = p_reg[10][31:0]; elem3 = '0;
            end
            default:
            begin
                elem0 = pos_reg[0]; elem1 = pos_reg[1]; elem2 = pos_reg[2];
                elem3 = ypu_pkg::OneQ16;
            end
        endcase
    end

endmodule
